FILE: rtl/matrix_vector_mac_assert.svh
// Assertion macros shared by the RTL of the matrix-vector block.
// Each macro expects clk_i and rst_ni in scope.
`ifndef MATRIX_VECTOR_MAC_ASSERT_SVH
`define MATRIX_VECTOR_MAC_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define MVM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its trigger.
`define MVM_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that holds in the cycle after its trigger.
`define MVM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mvm_pkg.sv
package mvm_pkg;

  localparam int unsigned MAX_COLS_DEF   = 1024;
  localparam int unsigned DATA_WIDTH_DEF = 16;

  localparam int unsigned ELEM_W   = 16;
  localparam int unsigned ACC_W    = 48;
  localparam int unsigned ROW_W    = 16;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_ROW  = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_OVERSIZE = 2'd2
  } status_e;

  // Control that travels with an item through the multiply-accumulate stages.
  typedef struct packed {
    logic             mac;
    logic             emit;
    logic             clr;
    status_e          status;
    logic [ROW_W-1:0] row;
  } mvm_ctrl_t;

endpackage

FILE: rtl/mvm_in_if.sv
interface mvm_in_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic signed [mvm_pkg::ELEM_W-1:0] element;
  logic                              last;

  modport source (output valid, output opcode, output element, output last, input ready);
  modport sink   (input valid, input opcode, input element, input last, output ready);
endinterface

FILE: rtl/mvm_out_if.sv
interface mvm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mvm_pkg::ACC_W-1:0]    row_sum;
  logic        [mvm_pkg::ROW_W-1:0]    row_number;
  logic        [mvm_pkg::STATUS_W-1:0] status;

  modport source (output valid, output row_sum, output row_number, output status, input ready);
  modport sink   (input valid, input row_sum, input row_number, input status, output ready);
endinterface

FILE: rtl/matrix_vector_mac.sv
// Channel  Direction  Word
// in_i     input      opcode (load or row element), element (Q4.12), last
// out_o    output     row_sum (Q24.24), row_number, status
//
// One word is taken per cycle; a row result reaches the output register after its
// last element is taken. The vector store is a single-port-write, registered-read
// memory; one read and one product per word set the pace. Reset clears all
// control state and the accumulator; the store itself is not cleared. The input
// stalls only while a finished result sits unclaimed and the next one is due.
`include "matrix_vector_mac_assert.svh"

module matrix_vector_mac #(
  parameter int unsigned MAX_COLS   = mvm_pkg::MAX_COLS_DEF,
  parameter int unsigned DATA_WIDTH = mvm_pkg::DATA_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  mvm_in_if.sink    in_i,
  mvm_out_if.source out_o
);
  import mvm_pkg::*;

  localparam int unsigned AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned LW = $clog2(MAX_COLS + 1);
  localparam int unsigned CW = $clog2(MAX_COLS + 2);
  localparam int unsigned PW = 2 * DATA_WIDTH;
  localparam logic [LW-1:0] L_MAX = LW'(MAX_COLS);
  localparam logic [CW-1:0] C_MAX = CW'(MAX_COLS);

  logic [DATA_WIDTH-1:0] vec_mem_q [MAX_COLS];

  logic [LW-1:0]    load_pos_q, load_pos_d, load_pos_inc;
  logic [LW-1:0]    vlen_q, vlen_d;
  logic             ovs_q, ovs_d;
  logic [CW-1:0]    col_q, col_d, col_inc;
  logic [ROW_W-1:0] row_cnt_q, row_cnt_d;

  logic                  go, accept, wr_en;
  logic [DATA_WIDTH-1:0] value;
  mvm_ctrl_t             ctrl_d;

  logic                         s1_valid_q, s2_valid_q;
  mvm_ctrl_t                    s1_q, s2_q;
  logic signed [DATA_WIDTH-1:0] s1_value_q, rdata_q;
  logic signed [PW-1:0]         prod_raw, prod_d, prod_q;
  logic signed [ACC_W-1:0]      prod_ext, acc_sum, acc_q;

  logic                    out_valid_q;
  logic signed [ACC_W-1:0] out_sum_q;
  logic [ROW_W-1:0]        out_row_q;
  status_e                 out_status_q;

  // Take the low DATA_WIDTH bits of the element; a wider store sees it unsigned.
  if (DATA_WIDTH <= ELEM_W) begin : g_val_narrow
    assign value = in_i.element[DATA_WIDTH-1:0];
  end else begin : g_val_wide
    assign value = {{(DATA_WIDTH - ELEM_W){1'b0}}, in_i.element};
  end

  if (PW >= ACC_W) begin : g_prod_trunc
    assign prod_ext = prod_q[ACC_W-1:0];
  end else begin : g_prod_sext
    assign prod_ext = {{(ACC_W - PW){prod_q[PW-1]}}, prod_q};
  end

  // The pipeline moves unless a result is due and the output word is still held.
  assign go          = !(s2_valid_q && s2_q.emit) || !out_valid_q || out_o.ready;
  assign in_i.ready  = go;
  assign accept      = in_i.valid && go;

  always_comb begin
    load_pos_d   = load_pos_q;
    vlen_d       = vlen_q;
    ovs_d        = ovs_q;
    col_d        = col_q;
    row_cnt_d    = row_cnt_q;
    wr_en        = 1'b0;
    ctrl_d       = '0;
    ctrl_d.status = ST_OK;
    ctrl_d.row   = row_cnt_q;
    load_pos_inc = load_pos_q;
    col_inc      = (col_q <= C_MAX) ? col_q + CW'(1) : col_q;
    if (accept) begin
      if (in_i.opcode == OP_LOAD) begin
        // The first load of a new vector clears the oversize flag.
        if (load_pos_q == '0) begin
          ovs_d = 1'b0;
        end
        if (load_pos_q < L_MAX) begin
          wr_en        = 1'b1;
          load_pos_inc = load_pos_q + LW'(1);
        end else begin
          ovs_d = 1'b1;
        end
        if (in_i.last) begin
          vlen_d     = load_pos_inc;
          load_pos_d = '0;
          col_d      = '0;
          row_cnt_d  = '0;
          ctrl_d.clr = 1'b1;
        end else begin
          load_pos_d = load_pos_inc;
        end
      end else begin
        ctrl_d.mac = (col_q < CW'(vlen_q)) && (col_q < C_MAX);
        col_d      = col_inc;
        if (in_i.last) begin
          ctrl_d.emit = 1'b1;
          if (ovs_q) begin
            ctrl_d.status = ST_OVERSIZE;
          end else if (col_inc != CW'(vlen_q)) begin
            ctrl_d.status = ST_MISMATCH;
          end
          col_d     = '0;
          row_cnt_d = row_cnt_q + ROW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_pos_q <= '0;
      vlen_q     <= '0;
      ovs_q      <= 1'b0;
      col_q      <= '0;
      row_cnt_q  <= '0;
    end else begin
      load_pos_q <= load_pos_d;
      vlen_q     <= vlen_d;
      ovs_q      <= ovs_d;
      col_q      <= col_d;
      row_cnt_q  <= row_cnt_d;
    end
  end

  // Vector store: write at the load slot, registered read at the row column.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      vec_mem_q[load_pos_q[AW-1:0]] <= value;
    end
    if (accept) begin
      rdata_q <= vec_mem_q[col_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      s1_q       <= ctrl_d;
      s1_value_q <= value;
      s2_q       <= s1_q;
      prod_q     <= prod_d;
    end
  end

  // The product is formed on its own so that both factors stay signed.
  assign prod_raw = s1_value_q * rdata_q;
  assign prod_d   = s1_q.mac ? prod_raw : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (go) begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
    end
  end

  assign acc_sum = acc_q + prod_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (go && s2_valid_q) begin
        if (s2_q.clr || s2_q.emit) begin
          acc_q <= '0;
        end else begin
          acc_q <= acc_sum;
        end
      end
      if (go && s2_valid_q && s2_q.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && s2_valid_q && s2_q.emit) begin
      out_sum_q    <= acc_sum;
      out_row_q    <= s2_q.row;
      out_status_q <= s2_q.status;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.row_sum    = out_sum_q;
  assign out_o.row_number = out_row_q;
  assign out_o.status     = out_status_q;

  `MVM_ASSERT_ALWAYS(a_load_pos_range, load_pos_q <= L_MAX, "load position past capacity")
  `MVM_ASSERT_ALWAYS(a_col_range, col_q <= C_MAX + CW'(1), "column position past saturation")
  `MVM_ASSERT_IMPLY(a_stall_blocks_input,
    s2_valid_q && s2_q.emit && out_valid_q && !out_o.ready, !in_i.ready,
    "input taken while a result is blocked")
  `MVM_ASSERT_NEXT(a_vector_restart,
    accept && in_i.opcode == OP_LOAD && in_i.last,
    load_pos_q == '0 && row_cnt_q == '0 && col_q == '0,
    "last load did not restart the row count")
  `MVM_ASSERT_IMPLY(a_status_code, out_valid_q,
    out_status_q == ST_OK || out_status_q == ST_MISMATCH || out_status_q == ST_OVERSIZE,
    "result status code out of range")

endmodule

FILE: verif/mvm_row_checker.sv
`timescale 1ns / 1ps

module mvm_row_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  mvm_in_if           in_mon,
  mvm_out_if          out_mon,
  output int unsigned mismatches_o,
  output int unsigned rows_pending_o,
  output int unsigned rows_checked_o,
  output int unsigned rows_flagged_o
);
  import mvm_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct {
    logic [ACC_W-1:0] sum;
    logic [ROW_W-1:0] number;
    status_e          status;
  } row_result_t;

  // Shadow copy of the block's vector store and row state.
  logic signed [ELEM_W-1:0] vec_mem [MAX_COLS_DEF];
  int unsigned              vec_len  = 0;
  int unsigned              load_pos = 0;
  int unsigned              col_pos  = 0;
  bit                       oversize = 1'b0;
  logic [ACC_W-1:0]         dot_acc  = '0;
  logic [ROW_W-1:0]         row_idx  = '0;

  row_result_t rows_due[$];
  row_result_t got;
  row_result_t want;
  int unsigned mismatches   = 0;
  int unsigned rows_checked = 0;
  int unsigned rows_flagged = 0;

  task automatic advance_dot_product(input opcode_e op, input logic signed [ELEM_W-1:0] elem,
                                     input logic last);
    logic signed [2*ELEM_W-1:0] prod;
    row_result_t                res;
    if (op == OP_LOAD) begin
      // The first word of a new vector clears the oversize flag.
      if (load_pos == 0) oversize = 1'b0;
      if (load_pos < MAX_COLS_DEF) begin
        vec_mem[load_pos] = elem;
        load_pos++;
      end else begin
        oversize = 1'b1;
      end
      if (last) begin
        vec_len  = load_pos;
        load_pos = 0;
        col_pos  = 0;
        dot_acc  = '0;
        row_idx  = '0;
      end
    end else begin
      // Row words past the vector length are counted but not summed.
      if (col_pos < vec_len) begin
        prod    = elem * vec_mem[col_pos];
        dot_acc = dot_acc + {{(ACC_W - 2*ELEM_W){prod[2*ELEM_W-1]}}, prod};
      end
      if (col_pos <= MAX_COLS_DEF) col_pos++;
      if (last) begin
        res.sum    = dot_acc;
        res.number = row_idx;
        if (oversize) res.status = ST_OVERSIZE;
        else if (col_pos != vec_len) res.status = ST_MISMATCH;
        else res.status = ST_OK;
        rows_due.push_back(res);
        row_idx++;
        dot_acc = '0;
        col_pos = 0;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_mon.valid && in_mon.ready) begin
        advance_dot_product(opcode_e'(in_mon.opcode), in_mon.element, in_mon.last);
      end
      if (out_mon.valid && out_mon.ready) begin
        got.sum    = out_mon.row_sum;
        got.number = out_mon.row_number;
        got.status = status_e'(out_mon.status);
        if (rows_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("unexpected row result: sum %0d row %0d status %0d",
                     $signed(got.sum), got.number, got.status);
          end
        end else begin
          want = rows_due.pop_front();
          rows_checked++;
          if (want.status != ST_OK) rows_flagged++;
          if (got.sum !== want.sum || got.number !== want.number ||
              got.status !== want.status) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display({"row result mismatch: expected sum %0d row %0d status %s, ",
                        "got sum %0d row %0d status %0d"},
                       $signed(want.sum), want.number, want.status.name(),
                       $signed(got.sum), got.number, got.status);
            end
          end
        end
      end
    end
    mismatches_o   <= mismatches;
    rows_pending_o <= rows_due.size();
    rows_checked_o <= rows_checked;
    rows_flagged_o <= rows_flagged;
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import mvm_pkg::*;

  localparam int unsigned RANDOM_WORDS = 230;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned TAIL_CYCLES  = 10;

  logic clk_i;
  logic rst_ni;

  mvm_in_if  in_w ();
  mvm_out_if out_w ();

  matrix_vector_mac uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_w),
    .out_o  (out_w)
  );

  int unsigned mismatches;
  int unsigned rows_pending;
  int unsigned rows_checked;
  int unsigned rows_flagged;

  mvm_row_checker row_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon         (in_w),
    .out_mon        (out_w),
    .mismatches_o   (mismatches),
    .rows_pending_o (rows_pending),
    .rows_checked_o (rows_checked),
    .rows_flagged_o (rows_flagged)
  );

  int unsigned burst_left    = 0;
  int unsigned words_sent    = 0;
  int unsigned loads_sent    = 0;
  int unsigned holds_asked   = 0;
  int unsigned holds_granted = 0;
  int unsigned hold_left     = 0;
  int unsigned ready_mode    = 0;
  int unsigned mode_left     = 0;
  int unsigned ready_phase   = 0;
  int unsigned idle_cycles   = 0;
  int unsigned random_start  = 0;
  int unsigned pick          = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [ELEM_W-1:0] pick_element();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return ELEM_W'($urandom());
    endcase
  endfunction

  // Offers one word and returns once it has been taken. Gaps open between bursts.
  task automatic send_word(input opcode_e op, input logic [ELEM_W-1:0] elem, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(7, 15);
      if (gap != 0) begin
        in_w.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_w.valid   <= 1'b1;
    in_w.opcode  <= op;
    in_w.element <= elem;
    in_w.last    <= last;
    do @(posedge clk_i); while (!in_w.ready);
    words_sent++;
    if (op == OP_LOAD) loads_sent++;
  endtask

  task automatic send_run(input opcode_e op, input int unsigned len, input bit close,
                          input bit fixed_en, input logic [ELEM_W-1:0] fixed_val);
    for (int unsigned i = 0; i < len; i++) begin
      send_word(op, fixed_en ? fixed_val : pick_element(), close && (i == len - 1));
    end
  endtask

  task automatic wait_rows_drained();
    in_w.valid <= 1'b0;
    do @(posedge clk_i); while (rows_pending != 0);
  endtask

  // Loads a vector, sometimes with row words slipped into the load, then streams rows.
  task automatic gemv_sequence();
    int unsigned len;
    int unsigned split;
    int unsigned row_len;
    case ($urandom_range(0, 19))
      0:             len = $urandom_range(41, 160);
      1, 2, 3, 4, 5: len = $urandom_range(9, 40);
      default:       len = $urandom_range(1, 8);
    endcase
    if (len > 1 && $urandom_range(0, 9) == 0) begin
      split = $urandom_range(1, len - 1);
      send_run(OP_LOAD, split, 1'b0, 1'b0, '0);
      send_run(OP_ROW, $urandom_range(1, 3), 1'($urandom_range(0, 1)), 1'b0, '0);
      send_run(OP_LOAD, len - split, 1'b1, 1'b0, '0);
    end else begin
      send_run(OP_LOAD, len, 1'b1, 1'b0, '0);
    end
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 9))
        0:       row_len = $urandom_range(1, len);
        1:       row_len = len + $urandom_range(1, 4);
        default: row_len = len;
      endcase
      send_run(OP_ROW, row_len, 1'b1, 1'b0, '0);
    end
  endtask

  // Receiver: changes its stall pattern every so often, and honors long hold requests.
  initial begin
    out_w.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && holds_granted != holds_asked) begin
        hold_left = HOLD_CYCLES;
        holds_granted++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_w.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(20, 120);
        end
        mode_left--;
        ready_phase++;
        case (ready_mode)
          0:       out_w.ready <= 1'b1;
          1:       out_w.ready <= ($urandom_range(0, 3) != 0);
          2:       out_w.ready <= (ready_phase % 3 != 0);
          default: out_w.ready <= ($urandom_range(0, 1) == 1);
        endcase
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: %0d cycles without a word moving", IDLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_ni       <= 1'b0;
    in_w.valid   <= 1'b0;
    in_w.opcode  <= OP_LOAD;
    in_w.element <= '0;
    in_w.last    <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With no vector loaded every row sums to zero and is flagged.
    send_word(OP_ROW, 16'h1234, 1'b1);
    send_word(OP_ROW, 16'h7fff, 1'b0);
    send_word(OP_ROW, 16'h8000, 1'b1);
    send_word(OP_LOAD, 16'h7fff, 1'b0);
    send_word(OP_LOAD, 16'h8000, 1'b0);
    send_word(OP_LOAD, 16'h0001, 1'b1);
    send_word(OP_ROW, 16'h7fff, 1'b0);
    send_word(OP_ROW, 16'h8000, 1'b0);
    send_word(OP_ROW, 16'hffff, 1'b1);
    send_word(OP_ROW, 16'h0005, 1'b1);
    for (int unsigned i = 1; i <= 5; i++) send_word(OP_ROW, ELEM_W'(i), i == 5);
    // A row arriving mid-load sees the old length and a partly rewritten store.
    send_word(OP_LOAD, 16'h0064, 1'b0);
    send_word(OP_LOAD, 16'h00c8, 1'b0);
    send_word(OP_ROW, 16'h0003, 1'b0);
    send_word(OP_ROW, 16'h0004, 1'b0);
    send_word(OP_ROW, 16'h0005, 1'b1);
    send_word(OP_LOAD, 16'h012c, 1'b1);
    send_word(OP_ROW, 16'h0001, 1'b0);
    send_word(OP_ROW, 16'h0001, 1'b0);
    send_word(OP_ROW, 16'h0001, 1'b1);
    send_word(OP_LOAD, 16'hffff, 1'b1);
    send_word(OP_ROW, 16'h8000, 1'b1);
    wait_rows_drained();

    // Oversize vector of the most negative value: the extra loads are dropped, every
    // row is flagged, and rows of the same value make each product the largest one.
    send_run(OP_LOAD, MAX_COLS_DEF + 2, 1'b1, 1'b1, 16'h8000);
    repeat (3) send_run(OP_ROW, $urandom_range(1, 8), 1'b1, 1'b1, 16'h8000);
    send_run(OP_ROW, $urandom_range(1, 8), 1'b1, 1'b0, '0);
    send_run(OP_LOAD, 4, 1'b1, 1'b0, '0);
    send_run(OP_ROW, 4, 1'b1, 1'b0, '0);
    wait_rows_drained();

    random_start = words_sent;
    // Long receiver hold while the sender keeps offering words.
    holds_asked++;
    while (words_sent - random_start < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        gemv_sequence();
      end else if (pick < 92) begin
        repeat ($urandom_range(3, 12)) begin
          send_word(opcode_e'($urandom_range(0, 1)), pick_element(), $urandom_range(0, 3) == 0);
        end
      end else if (pick < 96) begin
        wait_rows_drained();
      end else begin
        holds_asked++;
      end
    end

    wait_rows_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d words (%0d loads, %0d row elements), an oversize vector among them.",
             words_sent, loads_sent, words_sent - loads_sent);
    $display("Checked %0d row results, %0d of them flagged, under %0d long receiver holds.",
             rows_checked, rows_flagged, holds_granted);
    if (mismatches == 0 && rows_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/mvm_pkg.sv
rtl/mvm_in_if.sv
rtl/mvm_out_if.sv
rtl/matrix_vector_mac.sv
verif/mvm_row_checker.sv
verif/tb.sv
